// File: hw/rtl/dett_pkg.sv
package dett_pkg;

  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned EVENT_W   = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic ACT_SCHEDULE = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_EXPIRED  = 2'd2
  } dett_kind_e;

  typedef struct packed {
    logic               action;
    logic [DELAY_W-1:0] delay_ms;
    logic [EVENT_W-1:0] event_id;
  } dett_in_t;

  typedef struct packed {
    dett_kind_e         kind;
    logic [EVENT_W-1:0] out_event_id;
    logic               last;
  } dett_out_t;

  typedef struct packed {
    logic [DELAY_W-1:0]   delay;
    logic [ELAPSED_W-1:0] elapsed;
    logic [EVENT_W-1:0]   event_id;
  } dett_entry_t;

  localparam int unsigned ENTRY_W = $bits(dett_entry_t);

endpackage

// File: hw/rtl/dett_ram.sv
module dett_ram #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned WIDTH  = 49,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: hw/rtl/dett_age.sv
module dett_age (
  input  dett_pkg::dett_entry_t entry_i,
  output dett_pkg::dett_entry_t entry_o,
  output logic                  expired_o
);
  import dett_pkg::*;

  logic [ELAPSED_W-1:0] elapsed_inc;

  // saturating one millisecond step
  assign elapsed_inc = (entry_i.elapsed == ELAPSED_MAX) ? entry_i.elapsed
                                                        : entry_i.elapsed + 1'b1;

  always_comb begin
    entry_o         = entry_i;
    entry_o.elapsed = elapsed_inc;
  end

  assign expired_o = elapsed_inc > {{(ELAPSED_W - DELAY_W){1'b0}}, entry_i.delay};

endmodule

// File: hw/rtl/delayed_event_timer_table.sv
// One-shot delayed event table. A schedule item (action 0) is taken whenever
// busy is low and answers in the next cycle with accepted or table full;
// schedules can follow each other in every cycle. A tick item (action 1) walks
// the active slots through the slot memory's single read port, one slot per
// cycle, with busy high until the walk ends; busy does not rise on an empty
// table. Expired events come out in slot order, at most one per cycle, each
// marked by a one-cycle res_strobe_o on res_o; the receiver cannot stall them,
// so it must take every strobe. An event with delay d fires on the (d+1)-th
// tick after it was scheduled. No clearing pass is needed after reset.
module delayed_event_timer_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  dett_pkg::dett_in_t  cmd_i,
  output logic                res_strobe_o,
  output dett_pkg::dett_out_t res_o
);
  import dett_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;    // active slots, table kept compact
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;  // next slot to read during a tick
  logic [CNT_W-1:0]  w_q, w_d;            // next slot for a survivor
  logic              rvalid_q, rvalid_d;  // read data valid this cycle
  logic              pend_valid_q, pend_valid_d;
  logic [EVENT_W-1:0] pend_id_q, pend_id_d;
  logic              res_strobe_q, res_strobe_d;
  dett_out_t         res_q, res_d;

  logic              accept;
  logic              table_full;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  dett_entry_t       ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  dett_entry_t       rd_entry;
  dett_entry_t       upd_entry;
  logic              expired;

  assign accept     = start && !busy;
  assign table_full = (count_q == CNT_W'(NUM_SLOTS));
  assign rd_entry   = dett_entry_t'(ram_rdata);

  dett_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (ENTRY_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // elapsed update and expiry test on the slot just read
  dett_age u_age (
    .entry_i  (rd_entry),
    .entry_o  (upd_entry),
    .expired_o(expired)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    w_d          = w_q;
    rvalid_d     = 1'b0;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    res_strobe_d = 1'b0;
    res_d        = res_q;

    ram_we             = 1'b0;
    ram_waddr          = count_q[IDX_W-1:0];
    ram_wdata.delay    = cmd_i.delay_ms;
    ram_wdata.elapsed  = '0;
    ram_wdata.event_id = cmd_i.event_id;
    ram_re             = 1'b0;
    ram_raddr          = rd_idx_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.action == ACT_SCHEDULE) begin
            res_strobe_d       = 1'b1;
            res_d.out_event_id = cmd_i.event_id;
            res_d.last         = 1'b1;
            if (table_full) begin
              res_d.kind = KIND_FULL;
            end else begin
              // first free slot is always count
              res_d.kind = KIND_ACCEPTED;
              ram_we     = 1'b1;
              count_d    = count_q + 1'b1;
            end
          end else if (count_q != '0) begin
            state_d      = ST_SCAN;
            rd_idx_d     = '0;
            w_d          = '0;
            pend_valid_d = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        // read side runs one slot ahead of the processing side
        if (rd_idx_q < count_q) begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
          rvalid_d = 1'b1;
        end

        if (rvalid_q) begin
          if (expired) begin
            // hold the newest expiry back until we know whether it is the last
            if (pend_valid_q) begin
              res_strobe_d       = 1'b1;
              res_d.kind         = KIND_EXPIRED;
              res_d.out_event_id = pend_id_q;
              res_d.last         = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = upd_entry.event_id;
          end else begin
            // survivor moves down; w never passes the slot being read
            ram_we    = 1'b1;
            ram_waddr = w_q[IDX_W-1:0];
            ram_wdata = upd_entry;
            w_d       = w_q + 1'b1;
          end
        end else if (rd_idx_q == count_q) begin
          // walk finished: flush the held expiry as the last result
          if (pend_valid_q) begin
            res_strobe_d       = 1'b1;
            res_d.kind         = KIND_EXPIRED;
            res_d.out_event_id = pend_id_q;
            res_d.last         = 1'b1;
          end
          pend_valid_d = 1'b0;
          count_d      = w_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      rd_idx_q     <= '0;
      w_q          <= '0;
      rvalid_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rd_idx_q     <= rd_idx_d;
      w_q          <= w_d;
      rvalid_q     <= rvalid_d;
      pend_valid_q <= pend_valid_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    res_q     <= res_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import dett_pkg::*;

  // generous cycle limit: every item costs at most an idle gap plus a slot walk
  // over the whole table, so the run stays far below it
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned RAND_ITEMS  = 440;

  // shadow of the timer table plus the queue of results still owed by the block
  class timer_table_tracker;
    bit                   slot_live[NUM_SLOTS];
    logic [DELAY_W-1:0]   slot_delay[NUM_SLOTS];
    logic [ELAPSED_W-1:0] slot_elapsed[NUM_SLOTS];
    logic [EVENT_W-1:0]   slot_event[NUM_SLOTS];
    int                   live_count;
    dett_out_t            due_results[$];
    int                   errors;

    function new();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      live_count = 0;
      errors     = 0;
    endfunction

    function void owe(dett_kind_e kind, logic [EVENT_W-1:0] id, logic last);
      dett_out_t r;
      r.kind         = kind;
      r.out_event_id = id;
      r.last         = last;
      due_results.push_back(r);
    endfunction

    // called for every item the block accepts
    function void take_command(dett_in_t it);
      dett_out_t fired[NUM_SLOTS];
      int        n_fired;
      int        w;
      n_fired = 0;
      w       = 0;
      if (it.action == ACT_SCHEDULE) begin
        if (live_count >= NUM_SLOTS) begin
          owe(KIND_FULL, it.event_id, 1'b1);
        end else begin
          slot_live[live_count]    = 1'b1;
          slot_delay[live_count]   = it.delay_ms;
          slot_elapsed[live_count] = '0;
          slot_event[live_count]   = it.event_id;
          live_count++;
          owe(KIND_ACCEPTED, it.event_id, 1'b1);
        end
      end else begin
        // one millisecond passes for every live entry
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_live[i] && slot_elapsed[i] != ELAPSED_MAX) slot_elapsed[i]++;
        end
        // expire in slot order, slide survivors down
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_live[i]) begin
            if (slot_elapsed[i] > slot_delay[i]) begin
              fired[n_fired].kind         = KIND_EXPIRED;
              fired[n_fired].out_event_id = slot_event[i];
              fired[n_fired].last         = 1'b0;
              n_fired++;
            end else begin
              slot_delay[w]   = slot_delay[i];
              slot_elapsed[w] = slot_elapsed[i];
              slot_event[w]   = slot_event[i];
              slot_live[w]    = 1'b1;
              w++;
            end
          end
        end
        for (int i = w; i < NUM_SLOTS; i++) slot_live[i] = 1'b0;
        live_count = w;
        for (int k = 0; k < n_fired; k++) begin
          owe(KIND_EXPIRED, fired[k].out_event_id, k == n_fired - 1);
        end
      end
    endfunction

    function void check_result(dett_out_t got);
      dett_out_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d id %h last %0b",
               got.kind, got.out_event_id, got.last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.out_event_id !== want.out_event_id) begin
        $error("out_event_id: expected %h, got %h", want.out_event_id, got.out_event_id);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int owed();
      return due_results.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  dett_in_t            cmd_i;
  logic                res_strobe_o;
  dett_out_t           res_o;

  timer_table_tracker  tracker;
  int unsigned         cycle_cnt;
  int                  big_delays_left;

  delayed_event_timer_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // sample at the rising edge: accepted items feed the shadow table first,
  // then any strobed result is checked against the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) tracker.take_command(cmd_i);
      if (res_strobe_o) tracker.check_result(res_o);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic dett_in_t make_cmd(logic act, logic [DELAY_W-1:0] d,
                                        logic [EVENT_W-1:0] id);
    dett_in_t c;
    c.action   = act;
    c.delay_ms = d;
    c.event_id = id;
    return c;
  endfunction

  // random item: schedules mostly with short delays so entries cycle through
  // the table; at most two longer delays (13 to 65535) may stay far longer
  function automatic dett_in_t random_cmd(int sched_pct);
    dett_in_t c;
    c.action   = ($urandom_range(0, 99) < sched_pct) ? ACT_SCHEDULE : ACT_TICK;
    c.event_id = EVENT_W'($urandom);
    c.delay_ms = DELAY_W'($urandom_range(0, 12));
    if (c.action == ACT_SCHEDULE && big_delays_left > 0 && $urandom_range(0, 59) == 0) begin
      c.delay_ms = DELAY_W'($urandom_range(13, 65535));
      big_delays_left--;
    end
    if (c.action == ACT_TICK && $urandom_range(0, 3) == 0) c.delay_ms = DELAY_W'($urandom);
    return c;
  endfunction

  // called at a falling edge; returns with start still high at the falling edge
  // once the item is accepted and busy is low, so the next item can follow without a gap
  task automatic issue(input dett_in_t c, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < 36) begin
      start = 1'b0;
      // mostly short gaps, sometimes long enough to cover a whole slot walk
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 14) : $urandom_range(1, 3);
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    cmd_i = c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold the sender off until everything owed has come back
  task automatic drain();
    start = 1'b0;
    while (tracker.owed() != 0) @(negedge clk_i);
    repeat (NUM_SLOTS + 4) @(negedge clk_i);
  endtask

  task automatic run_directed();
    // tick on an empty table: nothing comes back
    issue(make_cmd(ACT_TICK, 16'hFFFF, 16'hFFFF), 1'b1);
    issue(make_cmd(ACT_SCHEDULE, 16'd0, 16'h0000), 1'b1);
    issue(make_cmd(ACT_SCHEDULE, 16'd1, 16'hFFFF), 1'b1);
    issue(make_cmd(ACT_SCHEDULE, 16'd0, 16'h5A5A), 1'b1);
    // both zero-delay entries fire together, the survivor slides to slot 0
    issue(make_cmd(ACT_TICK, 16'h0000, 16'h0000), 1'b1);
    issue(make_cmd(ACT_TICK, 16'h1234, 16'hABCD), 1'b1);
    // fill all slots, alternating zero and nonzero delays
    for (int k = 0; k < NUM_SLOTS; k++) begin
      issue(make_cmd(ACT_SCHEDULE, (k % 2) ? 16'd0 : 16'((k % 3) + 1), 16'h1000 + 16'(k)), 1'b1);
    end
    // table full, twice
    issue(make_cmd(ACT_SCHEDULE, 16'd5, 16'hBEEF), 1'b1);
    issue(make_cmd(ACT_SCHEDULE, 16'hFFFF, 16'hFFFF), 1'b1);
    // expire in waves until the table is empty, then one more empty tick
    repeat (5) issue(make_cmd(ACT_TICK, DELAY_W'($urandom), EVENT_W'($urandom)), 1'b1);
  endtask

  initial begin
    tracker         = new();
    cycle_cnt       = 0;
    big_delays_left = 2;
    rst_ni          = 1'b0;
    start           = 1'b0;
    cmd_i           = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();

    // random part: schedule-heavy first so the table fills up, tick-heavy later
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 150) drain();
      issue(random_cmd((n < 230) ? 60 : 30), !(n >= 260 && n < 360));
    end

    drain();
    if (tracker.errors == 0 && tracker.owed() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: delayed_event_timer_table.f
hw/rtl/dett_pkg.sv
hw/rtl/dett_ram.sv
hw/rtl/dett_age.sv
hw/rtl/delayed_event_timer_table.sv
tb/sv/testbench.sv
